/* hw/rtl/msa_pkg.sv */
package msa_pkg;

   localparam int OFFSET_BITS = 16;
   localparam int MAX_RECORDS = 1024;
   localparam int ADDR_BITS = $clog2(MAX_RECORDS);
   localparam int DEPTH_BITS = $clog2(MAX_RECORDS + 1);
   localparam int POP_BITS = 11;
   localparam int OP_BITS = 3;
   localparam int STATUS_BITS = 2;

   localparam logic [OFFSET_BITS-1:0] ALLOC_MARK_BYTES = OFFSET_BITS'(4);
   localparam logic [OFFSET_BITS-1:0] CHUNK_MARK_BYTES = OFFSET_BITS'(12);

   localparam logic [OP_BITS-1:0] OP_ALLOC     = 3'd0;
   localparam logic [OP_BITS-1:0] OP_POP       = 3'd1;
   localparam logic [OP_BITS-1:0] OP_MARK      = 3'd2;
   localparam logic [OP_BITS-1:0] OP_POP_CHUNK = 3'd3;
   localparam logic [OP_BITS-1:0] OP_CLEAR     = 3'd4;

   localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY    = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POP,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MODE_ONE,
      MODE_CHUNK,
      MODE_ALL
   } mode_type;

   typedef struct packed {
      logic [OP_BITS-1:0]     op;
      logic [OFFSET_BITS-1:0] request_bytes;
   } req_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [OFFSET_BITS-1:0] block_offset;
      logic [OFFSET_BITS-1:0] used_bytes;
      logic [POP_BITS-1:0]    pops_done;
   } rsp_type;

   typedef struct packed {
      logic    load;
      rsp_type payload;
   } rsp_load_type;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] prev_back;
      logic [OFFSET_BITS-1:0] prev_chunk;
   } rec_type;

endpackage

/* hw/rtl/msa_ram.sv */
module msa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/msa_rsp_stage.sv */
module msa_rsp_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  msa_pkg::rsp_load_type result,
   output logic                  out_free,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output msa_pkg::rsp_type      rsp_payload
);

   logic             valid_ff;
   logic             valid_in;
   msa_pkg::rsp_type payload_ff;

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (result.load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.load) begin
         payload_ff <= result.payload;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_payload = payload_ff;

endmodule

/* hw/rtl/msa_engine.sv */
module msa_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  msa_pkg::req_type                    req_payload,
   input  logic                                csr_valid,
   input  logic [msa_pkg::OFFSET_BITS-1:0]     csr_data,
   output msa_pkg::rsp_load_type               result,
   input  logic                                out_free
);

   localparam int OB = msa_pkg::OFFSET_BITS;
   localparam int AB = msa_pkg::ADDR_BITS;
   localparam int DB = msa_pkg::DEPTH_BITS;
   localparam int PB = msa_pkg::POP_BITS;

   msa_pkg::state_type state_ff, state_in;
   msa_pkg::mode_type  mode_ff, mode_in;

   logic [OB-1:0] front_ff, front_in;
   logic [OB-1:0] back_ff, back_in;
   logic [OB-1:0] chunk_ff, chunk_in;
   logic [OB-1:0] used_ff, used_in;
   logic [DB-1:0] depth_ff, depth_in;
   logic [OB-1:0] cap_ff, cap_in;
   logic [OB-1:0] target_ff, target_in;
   logic [msa_pkg::STATUS_BITS-1:0] status_ff, status_in;
   logic [OB-1:0] offset_ff, offset_in;
   logic [PB-1:0] pops_ff, pops_in;

   logic            accept;
   logic            start_pop;
   logic            pop_more;
   logic            can_pop;
   logic            full;
   logic            ovf;
   logic [OB-1:0]   bytes_sel;
   logic [OB+1:0]   nf_wide;
   logic [OB-1:0]   data_ofs;
   logic [OB-1:0]   nf_pop;
   logic [DB-1:0]   depth_dec;

   logic             mem_we;
   logic [AB-1:0]    mem_waddr;
   msa_pkg::rec_type mem_wdata;
   logic             mem_re;
   logic [AB-1:0]    mem_raddr;
   msa_pkg::rec_type mem_rdata;

   msa_ram #(
      .WIDTH($bits(msa_pkg::rec_type)),
      .DEPTH(msa_pkg::MAX_RECORDS)
   ) u_rec_ram (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_en  (mem_re),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   assign req_stall = (state_ff != msa_pkg::ST_IDLE);
   assign accept = req_valid && !req_stall;

   assign bytes_sel = (req_payload.op == msa_pkg::OP_MARK) ? msa_pkg::CHUNK_MARK_BYTES
                                                            : req_payload.request_bytes;
   assign nf_wide = {2'b00, front_ff} + {2'b00, bytes_sel} +
                    {2'b00, msa_pkg::ALLOC_MARK_BYTES};
   assign data_ofs = front_ff + msa_pkg::ALLOC_MARK_BYTES;
   assign full = (depth_ff >= DB'(msa_pkg::MAX_RECORDS));
   assign ovf = (nf_wide > {2'b00, cap_ff}) || full;
   assign can_pop = (depth_ff != '0) && (front_ff != '0);
   assign nf_pop = (back_ff >= msa_pkg::ALLOC_MARK_BYTES) ?
                   (back_ff - msa_pkg::ALLOC_MARK_BYTES) : '0;
   assign depth_dec = depth_ff - DB'(1);

   always_comb begin
      start_pop = 1'b0;
      mode_in = mode_ff;
      unique case (req_payload.op)
         msa_pkg::OP_POP: begin
            start_pop = can_pop;
            mode_in = msa_pkg::MODE_ONE;
         end
         msa_pkg::OP_POP_CHUNK: begin
            if (chunk_ff != '0) begin
               start_pop = (depth_ff != '0);
               mode_in = msa_pkg::MODE_CHUNK;
            end else begin
               start_pop = can_pop;
               mode_in = msa_pkg::MODE_ALL;
            end
         end
         msa_pkg::OP_CLEAR: begin
            start_pop = can_pop;
            mode_in = msa_pkg::MODE_ALL;
         end
         default: begin
            start_pop = 1'b0;
         end
      endcase
      if (!accept) begin
         start_pop = 1'b0;
         mode_in = mode_ff;
      end
   end

   always_comb begin
      unique case (mode_ff)
         msa_pkg::MODE_ALL:   pop_more = (depth_dec != '0) && (nf_pop != '0);
         msa_pkg::MODE_CHUNK: pop_more = (back_ff != target_ff) && (depth_dec != '0);
         default:             pop_more = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         msa_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = start_pop ? msa_pkg::ST_POP : msa_pkg::ST_DONE;
            end
         end
         msa_pkg::ST_POP: begin
            state_in = pop_more ? msa_pkg::ST_POP : msa_pkg::ST_DONE;
         end
         msa_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = msa_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = msa_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      front_in = front_ff;
      back_in = back_ff;
      chunk_in = chunk_ff;
      used_in = used_ff;
      depth_in = depth_ff;
      target_in = target_ff;
      status_in = status_ff;
      offset_in = offset_ff;
      pops_in = pops_ff;
      cap_in = csr_valid ? csr_data : cap_ff;
      mem_we = 1'b0;
      mem_waddr = depth_ff[AB-1:0];
      mem_wdata.prev_back = back_ff;
      mem_wdata.prev_chunk = '0;
      mem_re = 1'b0;
      mem_raddr = depth_dec[AB-1:0];
      result.load = 1'b0;
      result.payload.status = status_ff;
      result.payload.block_offset = offset_ff;
      result.payload.used_bytes = used_ff;
      result.payload.pops_done = pops_ff;

      unique case (state_ff)
         msa_pkg::ST_IDLE: begin
            if (accept) begin
               status_in = msa_pkg::STATUS_OK;
               offset_in = '0;
               pops_in = '0;
               target_in = chunk_ff;
               mem_re = start_pop;
               unique case (req_payload.op)
                  msa_pkg::OP_ALLOC, msa_pkg::OP_MARK: begin
                     if (ovf) begin
                        status_in = msa_pkg::STATUS_OVERFLOW;
                     end else begin
                        mem_we = 1'b1;
                        if (req_payload.op == msa_pkg::OP_MARK) begin
                           mem_wdata.prev_chunk = chunk_ff;
                           chunk_in = data_ofs;
                        end
                        offset_in = data_ofs;
                        back_in = data_ofs;
                        front_in = nf_wide[OB-1:0];
                        used_in = used_ff + bytes_sel + msa_pkg::ALLOC_MARK_BYTES;
                        depth_in = depth_ff + DB'(1);
                     end
                  end
                  msa_pkg::OP_POP, msa_pkg::OP_CLEAR: begin
                     if (!can_pop) begin
                        status_in = msa_pkg::STATUS_EMPTY;
                     end
                  end
                  msa_pkg::OP_POP_CHUNK: begin
                     if (chunk_ff != '0) begin
                        if (depth_ff == '0) begin
                           chunk_in = '0;
                        end
                     end else if (used_ff == '0 && depth_ff == '0) begin
                        status_in = msa_pkg::STATUS_EMPTY;
                     end
                  end
                  default: begin
                     status_in = msa_pkg::STATUS_OK;
                  end
               endcase
            end
         end
         msa_pkg::ST_POP: begin
            if (back_ff == chunk_ff && chunk_ff != '0) begin
               chunk_in = mem_rdata.prev_chunk;
            end
            used_in = used_ff - (front_ff - nf_pop);
            front_in = nf_pop;
            back_in = mem_rdata.prev_back;
            depth_in = depth_dec;
            pops_in = (pops_ff == '1) ? pops_ff : pops_ff + PB'(1);
            if (mode_ff == msa_pkg::MODE_CHUNK && back_ff != target_ff &&
                depth_dec == '0) begin
               chunk_in = '0;
            end
            mem_re = pop_more;
            mem_raddr = depth_ff[AB-1:0] - AB'(2);
         end
         msa_pkg::ST_DONE: begin
            result.load = out_free;
         end
         default: begin
            result.load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msa_pkg::ST_IDLE;
         mode_ff <= msa_pkg::MODE_ONE;
         front_ff <= '0;
         back_ff <= '0;
         chunk_ff <= '0;
         used_ff <= '0;
         depth_ff <= '0;
         cap_ff <= '1;
      end else begin
         state_ff <= state_in;
         mode_ff <= mode_in;
         front_ff <= front_in;
         back_ff <= back_in;
         chunk_ff <= chunk_in;
         used_ff <= used_in;
         depth_ff <= depth_in;
         cap_ff <= cap_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff <= target_in;
      status_ff <= status_in;
      offset_ff <= offset_in;
      pops_ff <= pops_in;
   end

   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DB'(msa_pkg::MAX_RECORDS))
      else $error("record depth beyond the record store");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("record store written and read in one cycle");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == msa_pkg::ST_POP |-> depth_ff != '0)
      else $error("pop step with no record on the stack");

   a_write_done: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> state_ff == msa_pkg::ST_DONE)
      else $error("allocation did not finish after its write");

   a_load_in_done: assert property (@(posedge clock) disable iff (reset)
      result.load |-> state_ff == msa_pkg::ST_DONE && out_free)
      else $error("result loaded outside the done state");

endmodule

/* hw/rtl/marked_stack_allocator_top.sv */
// Stack allocator over byte offsets with chunk marks. A request carries an
// operation (allocate, pop, mark chunk, pop chunk, clear) and a byte count;
// each request yields one response with status, data offset, bytes in use
// and the number of single pops performed.
// Requests are taken on req_valid while req_stall is low; responses leave on
// rsp_valid while rsp_stall is low. Capacity is written through csr_valid
// and csr_data, which is always ready and is meant to be written only while
// no request is in flight.
// One request is processed at a time. Allocate, mark chunk, failed requests
// and unknown operations go straight from the idle state to the done state,
// which loads the result into the response register. Pop, pop chunk and
// clear pass through the pop state, releasing one record per step, since
// each record's links come from the record memory, and then reach the done
// state. The next request is accepted once the done state returns to idle.
// The response register decouples the sides: the next request is accepted
// while a response still waits. If the receiver stalls, the following
// request completes but its result waits until the register frees, and
// req_stall stays high meanwhile.
// Reset empties the stack and sets the capacity to its maximum; the record
// memory needs no clearing, since only written entries are ever read.
module marked_stack_allocator_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  msa_pkg::req_type                req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output msa_pkg::rsp_type                rsp_payload,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [msa_pkg::OFFSET_BITS-1:0] csr_data
);

   msa_pkg::rsp_load_type result;
   logic                  out_free;

   assign csr_ready = 1'b1;

   msa_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .result     (result),
      .out_free   (out_free)
   );

   msa_rsp_stage u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .out_free   (out_free),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule
